/* rtl/bmc_pkg.sv */
// ---------------------------------------------------------------------------
// bmc_pkg: shared types and constants of the bracket match checker
// Character codes, bracket kinds, lexer modes, result status codes and the
// bracket event that travels from the lexer to the stack.
// ---------------------------------------------------------------------------
package bmc_pkg;

	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_NL     = 8'h0A;

	localparam int BYTE_W  = 8;
	localparam int FIELD_W = 32;
	localparam int OUT_W   = 72;

	typedef logic [1:0] brk_kind_t;
	localparam brk_kind_t KIND_PAREN  = 2'd0;
	localparam brk_kind_t KIND_SQUARE = 2'd1;
	localparam brk_kind_t KIND_CURLY  = 2'd2;

	typedef enum logic [2:0] {
		MODE_TEXT,
		MODE_SQUOTE,
		MODE_DQUOTE,
		MODE_SLASH,
		MODE_LINE,
		MODE_BLOCK,
		MODE_BLOCK_STAR
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_MISMATCH  = 3'd1,
		ST_UNDERFLOW = 3'd2,
		ST_UNCLOSED  = 3'd3,
		ST_OVERFLOW  = 3'd4
	} status_t;

	typedef struct packed {
		logic      push;
		logic      pop;
		brk_kind_t kind;
	} brk_evt_t;

	function automatic brk_kind_t bracket_kind(input logic [7:0] c);
		brk_kind_t k;
		case (c) inside
			CH_LPAREN, CH_RPAREN: k = KIND_PAREN;
			CH_LBRACK, CH_RBRACK: k = KIND_SQUARE;
			default:              k = KIND_CURLY;
		endcase
		return k;
	endfunction

endpackage

/* rtl/bmc_ram.sv */
// ---------------------------------------------------------------------------
// bmc_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ---------------------------------------------------------------------------
module bmc_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/bmc_counter.sv */
// ---------------------------------------------------------------------------
// bmc_counter: saturating event counter
// Counts one per qualifying beat, holds at all ones, reloads after a text.
// ---------------------------------------------------------------------------
module bmc_counter #(
	parameter int WIDTH = 32,
	parameter int INIT  = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             inc,
	input  logic             clear,
	output logic [WIDTH-1:0] count_n
);

	logic [WIDTH-1:0] count_q;

	always_comb begin
		count_n = count_q;
		if (step && inc && (count_q != {WIDTH{1'b1}})) begin
			count_n = count_q + WIDTH'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= WIDTH'(INIT);
		end else if (step) begin
			count_q <= clear ? WIDTH'(INIT) : count_n;
		end
	end

endmodule

/* rtl/bmc_lexer.sv */
// ---------------------------------------------------------------------------
// bmc_lexer: literal and comment skipping front end
// Tracks quotes and comments; reports bracket pushes and pops in plain text.
// ---------------------------------------------------------------------------
module bmc_lexer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              run,
	input  logic              last,
	input  logic [7:0]        text_byte,
	output bmc_pkg::brk_evt_t evt
);
	import bmc_pkg::*;

	mode_t mode_q, mode_n;
	logic  plain;

	always_comb begin
		mode_n = mode_q;
		unique case (mode_q)
			MODE_TEXT: begin
				if (text_byte == CH_SQUOTE) mode_n = MODE_SQUOTE;
				else if (text_byte == CH_DQUOTE) mode_n = MODE_DQUOTE;
				else if (text_byte == CH_SLASH) mode_n = MODE_SLASH;
			end
			MODE_SQUOTE: begin
				if (text_byte == CH_SQUOTE) mode_n = MODE_TEXT;
			end
			MODE_DQUOTE: begin
				if (text_byte == CH_DQUOTE) mode_n = MODE_TEXT;
			end
			MODE_SLASH: begin
				// a quote right after a lone slash still opens a literal
				if (text_byte == CH_SLASH) mode_n = MODE_LINE;
				else if (text_byte == CH_STAR) mode_n = MODE_BLOCK;
				else if (text_byte == CH_SQUOTE) mode_n = MODE_SQUOTE;
				else if (text_byte == CH_DQUOTE) mode_n = MODE_DQUOTE;
				else mode_n = MODE_TEXT;
			end
			MODE_LINE: begin
				if (text_byte == CH_NL) mode_n = MODE_TEXT;
			end
			MODE_BLOCK: begin
				if (text_byte == CH_STAR) mode_n = MODE_BLOCK_STAR;
			end
			MODE_BLOCK_STAR: begin
				if (text_byte == CH_SLASH) mode_n = MODE_TEXT;
				else if (text_byte != CH_STAR) mode_n = MODE_BLOCK;
			end
			default: mode_n = MODE_TEXT;
		endcase
	end

	// a byte after a lone slash is plain text again
	always_comb begin
		unique case (mode_q)
			MODE_TEXT:  plain = 1'b1;
			MODE_SLASH: plain = (text_byte != CH_SLASH) && (text_byte != CH_STAR);
			default:    plain = 1'b0;
		endcase
		evt.push = 1'b0;
		evt.pop  = 1'b0;
		evt.kind = bracket_kind(text_byte);
		if (run && plain) begin
			case (text_byte) inside
				CH_LPAREN, CH_LBRACK, CH_LBRACE: evt.push = 1'b1;
				CH_RPAREN, CH_RBRACK, CH_RBRACE: evt.pop  = 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_TEXT;
		end else if (step && last) begin
			mode_q <= MODE_TEXT;
		end else if (run) begin
			mode_q <= mode_n;
		end
	end

endmodule

/* rtl/bmc_stack.sv */
// ---------------------------------------------------------------------------
// bmc_stack: bracket stack with cached top and error latch
// Top entry sits in a register; entries below it live in a RAM whose next
// entry down is prefetched every cycle so pops can follow back to back.
// ---------------------------------------------------------------------------
module bmc_stack #(
	parameter int DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              last,
	input  bmc_pkg::brk_evt_t evt,
	output logic              err_ok,
	output bmc_pkg::status_t  final_status
);
	import bmc_pkg::*;

	localparam int LW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);

	logic [LW-1:0] level_q, level_n, level_nx, rd_level;
	brk_kind_t     top_q, top_n, second, rd_data, byp_data_q;
	status_t       err_q, err_n;
	logic          we, byp_q;
	logic [AW-1:0] waddr, raddr;

	assign second   = byp_q ? byp_data_q : rd_data;
	assign err_ok   = (err_q == ST_OK);
	assign waddr    = rd_level[AW-1:0];
	assign level_nx = (step && last) ? '0 : level_n;
	assign raddr    = rd_level[AW-1:0];

	always_comb begin
		level_n  = level_q;
		top_n    = top_q;
		err_n    = err_q;
		we       = 1'b0;
		rd_level = level_nx - LW'(2);
		if (step && evt.push) begin
			if (level_q == LW'(DEPTH)) begin
				err_n = ST_OVERFLOW;
			end else begin
				we      = (level_q != '0);
				level_n = level_q + LW'(1);
				top_n   = evt.kind;
			end
		end else if (step && evt.pop) begin
			if (level_q == '0) begin
				err_n = ST_UNDERFLOW;
			end else begin
				level_n = level_q - LW'(1);
				top_n   = second;
				if (top_q != evt.kind) err_n = ST_MISMATCH;
			end
		end
		// a push writes the old top one below the new top, which is also the
		// prefetch address, so the bypass always covers it
		if (we) rd_level = level_q - LW'(1);
		if (err_n != ST_OK) final_status = err_n;
		else if (level_n != '0) final_status = ST_UNCLOSED;
		else final_status = ST_OK;
	end

	bmc_ram #(
		.WIDTH ($bits(brk_kind_t)),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (top_q),
		.raddr (raddr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q    <= '0;
			top_q      <= KIND_PAREN;
			err_q      <= ST_OK;
			byp_q      <= 1'b0;
			byp_data_q <= KIND_PAREN;
		end else begin
			byp_q      <= we;
			byp_data_q <= top_q;
			if (step) begin
				level_q <= level_nx;
				top_q   <= top_n;
				err_q   <= last ? ST_OK : err_n;
			end
		end
	end

endmodule

/* rtl/bracket_match_checker.sv */
// ---------------------------------------------------------------------------
// bracket_match_checker: streaming bracket balance checker for source text
// Skips quoted literals and comments, matches ( [ { against ) ] } on a
// stack, and reports status, line count and byte count at end of text.
// ---------------------------------------------------------------------------
//
//  channel | dir | tdata (low bit up)                         | tlast
//  --------+-----+--------------------------------------------+------------
//  s_*     | in  | text_byte[7:0]                             | end_of_text
//  m_*     | out | check_status[2:0] line_count[34:3]         | -
//          |     | byte_count[66:35], zero fill to bit 71     |
//
//  Throughput: one byte per clock unless a stalled result beat holds a final
//  byte; an accepted input beat passes the input stage, then the result stage.
//  The stack top is held in a register and the entry below it is prefetched
//  from the stack RAM each cycle, so push/pop runs once per clock.
//  Reset is asynchronous; the stack RAM needs no clearing pass, since only
//  entries written under the current level are ever read.
//  A stalled result beat holds only the final byte of a text; other bytes
//  keep flowing while m_tready is low.
// ---------------------------------------------------------------------------
module bracket_match_checker #(
	parameter int STACK_DEPTH = 64,
	parameter int COUNT_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] text_byte
	input  logic        s_tlast,   // end_of_text
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata    // [2:0] check_status, [34:3] line_count,
	                               // [66:35] byte_count, [71:67] zero
);
	import bmc_pkg::*;

	// input stage
	logic                   v_s1, last_s1;
	logic [BYTE_W-1:0]      byte_s1;
	// result stage
	logic                   m_tvalid_q;
	logic [OUT_W-1:0]       m_tdata_q;

	logic                   out_free, adv, step, run, err_ok;
	brk_evt_t               evt;
	status_t                final_status;
	logic [COUNT_WIDTH-1:0] lines_n, bytes_n;
	logic [FIELD_W-1:0]     lines_f, bytes_f;

	// only the final byte of a text needs room in the result stage
	assign out_free = !m_tvalid_q || m_tready;
	assign adv      = !last_s1 || out_free;
	assign step     = v_s1 && adv;
	assign run      = step && err_ok;
	assign s_tready = !v_s1 || adv;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	bmc_lexer u_lexer (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.run       (run),
		.last      (last_s1),
		.text_byte (byte_s1),
		.evt       (evt)
	);

	bmc_stack #(
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.last         (last_s1),
		.evt          (evt),
		.err_ok       (err_ok),
		.final_status (final_status)
	);

	// every byte and every newline counts, inside literals and comments too
	bmc_counter #(
		.WIDTH (COUNT_WIDTH),
		.INIT  (1)
	) u_lines (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.inc     (byte_s1 == CH_NL),
		.clear   (last_s1),
		.count_n (lines_n)
	);

	bmc_counter #(
		.WIDTH (COUNT_WIDTH),
		.INIT  (0)
	) u_bytes (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.inc     (1'b1),
		.clear   (last_s1),
		.count_n (bytes_n)
	);

	// fit the counters to the 32-bit result fields
	generate
		if (COUNT_WIDTH >= FIELD_W) begin : g_trunc
			assign lines_f = lines_n[FIELD_W-1:0];
			assign bytes_f = bytes_n[FIELD_W-1:0];
		end else begin : g_ext
			assign lines_f = {{(FIELD_W - COUNT_WIDTH){1'b0}}, lines_n};
			assign bytes_f = {{(FIELD_W - COUNT_WIDTH){1'b0}}, bytes_n};
		end
	endgenerate

	// load a result beat on the final byte; drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (step && last_s1) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && last_s1) begin
			m_tdata_q <= {{(OUT_W - 2 * FIELD_W - $bits(status_t)){1'b0}},
				bytes_f, lines_f, final_status};
		end
	end

endmodule
